[hdl/atsl_pkg.sv]
// ----------------------------------------------------------------------------
// atsl_pkg - shared types and codes of the address to symbol lookup
// Function and status codes, the symbol entry layout and the request and
// result records passed between the top level and the lookup core.
// ----------------------------------------------------------------------------
package atsl_pkg;

	// default table depth
	localparam int ATSL_TABLE_DEPTH = 256;

	// function codes
	localparam logic [1:0] FN_CLEAR  = 2'd0;
	localparam logic [1:0] FN_INSERT = 2'd1;
	localparam logic [1:0] FN_LOOKUP = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_SKIP = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	// one stored entry; field order gives the sort order as a plain vector compare
	typedef struct packed {
		logic [31:0] value;
		logic [31:0] size;
		logic [7:0]  info;
		logic [31:0] name;
	} key_t;

	localparam int KEY_W = $bits(key_t);

	typedef struct packed {
		logic [1:0]  func;
		key_t        key;
		logic [31:0] query_address;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		key_t        hit;
		logic [8:0]  table_count;
	} res_t;

endpackage

[hdl/atsl_if.sv]
// ----------------------------------------------------------------------------
// atsl_if - request and result channels of the symbol lookup
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sym_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] entry_value;
	logic [31:0] entry_size;
	logic [7:0]  entry_info;
	logic [31:0] entry_name;
	logic [31:0] query_address;

	modport source (
		output valid, func, entry_value, entry_size, entry_info, entry_name, query_address,
		input  ready
	);
	modport sink (
		input  valid, func, entry_value, entry_size, entry_info, entry_name, query_address,
		output ready
	);
endinterface

interface sym_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] hit_value;
	logic [31:0] hit_size;
	logic [7:0]  hit_info;
	logic [31:0] hit_name;
	logic [8:0]  table_count;

	modport source (
		output valid, status, hit_value, hit_size, hit_info, hit_name, table_count,
		input  ready
	);
	modport sink (
		input  valid, status, hit_value, hit_size, hit_info, hit_name, table_count,
		output ready
	);
endinterface

[hdl/atsl_ram.sv]
// ----------------------------------------------------------------------------
// atsl_ram - generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module atsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/atsl_core.sv]
// ----------------------------------------------------------------------------
// atsl_core - sorted symbol table engine
// Holds the entries in one RAM in sorted order. Insert walks down from the
// end, moving larger entries up one slot; lookup is a binary search.
// ----------------------------------------------------------------------------
module atsl_core import atsl_pkg::*; #(
	parameter int TABLE_DEPTH = ATSL_TABLE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = $clog2(TABLE_DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INS   = 3'd1;
	localparam logic [2:0] S_INS0  = 3'd2;
	localparam logic [2:0] S_FIRST = 3'd3;
	localparam logic [2:0] S_LAST  = 3'd4;
	localparam logic [2:0] S_SRCH  = 3'd5;
	localparam logic [2:0] S_FETCH = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [IW-1:0] lo_q, lo_d;
	logic [IW-1:0] hi_q, hi_d;
	logic [IW-1:0] mid_q, mid_d;
	key_t          key_q, key_d;
	logic [31:0]   addr_q, addr_d;
	logic [1:0]    stat_q, stat_d;
	key_t          hit_q, hit_d;

	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	key_t          ram_wdata, ram_rdata;

	logic [IW-1:0] last_idx;
	logic [IW-1:0] span;
	logic          accept;
	logic [CW+8:0] cnt_ext;

	atsl_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_DONE);
	assign last_idx  = IW'(cnt_q - CW'(1));
	assign cnt_ext   = {9'd0, cnt_q};

	assign res.status      = stat_q;
	assign res.hit         = hit_q;
	assign res.table_count = cnt_ext[8:0];

	// sequencer; during insert the write goes to idx+1 while the read fetches
	// idx-1, so the two never touch the same entry
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		mid_d     = mid_q;
		key_d     = key_q;
		addr_d    = addr_q;
		stat_d    = stat_q;
		hit_d     = hit_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = key_q;
		ram_raddr = '0;
		span      = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_d  = req.key;
					addr_d = req.query_address;
					stat_d = STAT_OK;
					hit_d  = '0;
					state_d = S_DONE;
					case (req.func)
						FN_CLEAR: begin
							cnt_d = '0;
						end
						FN_INSERT: begin
							if (req.key.value == 32'd0 || req.key.name == 32'd0) begin
								stat_d = STAT_SKIP;
							end else if (cnt_q >= CW'(TABLE_DEPTH)) begin
								stat_d = STAT_FULL;
							end else if (cnt_q == '0) begin
								state_d = S_INS0;
							end else begin
								ram_raddr = last_idx;
								idx_d     = last_idx;
								state_d   = S_INS;
							end
						end
						FN_LOOKUP: begin
							if (cnt_q == '0) begin
								stat_d = STAT_MISS;
							end else begin
								ram_raddr = '0;
								state_d   = S_FIRST;
							end
						end
						default: begin
						end
					endcase
				end
			end
			// compare new key against entry idx, shift it up if larger
			S_INS: begin
				ram_we    = 1'b1;
				ram_waddr = IW'(idx_q + IW'(1));
				if (key_q < ram_rdata) begin
					ram_wdata = ram_rdata;
					if (idx_q == '0) begin
						state_d = S_INS0;
					end else begin
						ram_raddr = idx_q - IW'(1);
						idx_d     = idx_q - IW'(1);
					end
				end else begin
					ram_wdata = key_q;
					cnt_d     = cnt_q + CW'(1);
					state_d   = S_DONE;
				end
			end
			S_INS0: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = key_q;
				cnt_d     = cnt_q + CW'(1);
				state_d   = S_DONE;
			end
			// address below the first value misses
			S_FIRST: begin
				if (addr_q < ram_rdata.value) begin
					stat_d  = STAT_MISS;
					state_d = S_DONE;
				end else begin
					ram_raddr = last_idx;
					state_d   = S_LAST;
				end
			end
			// address at or above the last value misses
			S_LAST: begin
				if (ram_rdata.value <= addr_q) begin
					stat_d  = STAT_MISS;
					state_d = S_DONE;
				end else begin
					lo_d = '0;
					hi_d = last_idx;
					if (last_idx > IW'(1)) begin
						mid_d     = last_idx >> 1;
						ram_raddr = last_idx >> 1;
						state_d   = S_SRCH;
					end else begin
						ram_raddr = '0;
						state_d   = S_FETCH;
					end
				end
			end
			// one halving step per cycle, next probe issued at once
			S_SRCH: begin
				if (ram_rdata.value <= addr_q) begin
					lo_d = mid_q;
				end else begin
					hi_d = mid_q;
				end
				span = hi_d - lo_d;
				if (span > IW'(1)) begin
					mid_d     = lo_d + (span >> 1);
					ram_raddr = lo_d + (span >> 1);
				end else begin
					ram_raddr = lo_d;
					state_d   = S_FETCH;
				end
			end
			S_FETCH: begin
				hit_d   = ram_rdata;
				stat_d  = STAT_OK;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		mid_q  <= mid_d;
		key_q  <= key_d;
		addr_q <= addr_d;
		stat_q <= stat_d;
		hit_q  <= hit_d;
	end

	// table never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// the table is written only by an insert in progress
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_INS || state_q == S_INS0))
		else $error("table write outside insert");

	// search window stays open while probing
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (lo_q < mid_q && mid_q < hi_q))
		else $error("search probe outside window");

	// a lookup item leaves the count alone
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func == FN_LOOKUP) |=> $stable(cnt_q))
		else $error("lookup changed entry count");

endmodule

[hdl/address_to_symbol_lookup.sv]
// ----------------------------------------------------------------------------
// address_to_symbol_lookup - sorted symbol table with address lookup
// Keeps symbol entries sorted by value, size, info, name; resolves an address
// below the last value to the last entry whose value does not exceed it.
//
//   channel  dir  carries
//   req      in   func, entry_value, entry_size, entry_info, entry_name,
//                 query_address
//   res      out  status, hit_value, hit_size, hit_info, hit_name, table_count
//
// One item at a time. A lookup hit is found by a binary search on the table RAM,
// one read per cycle; an address below the first value or at or above the last
// value misses. Insert moves each larger entry up one slot, one RAM read and
// write per move. Reset empties the table at once, no sweep.
// A result waiting in the output register does not block the next item.
// ----------------------------------------------------------------------------
module address_to_symbol_lookup import atsl_pkg::*; #(
	parameter int TABLE_DEPTH = ATSL_TABLE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	sym_req_if.sink   req,
	sym_res_if.source res
);

	req_t core_req;
	res_t core_res;
	res_t out_q;
	logic core_valid;
	logic core_ready;
	logic out_vld_q;

	assign core_req.func          = req.func;
	assign core_req.key.value     = req.entry_value;
	assign core_req.key.size      = req.entry_size;
	assign core_req.key.info      = req.entry_info;
	assign core_req.key.name      = req.entry_name;
	assign core_req.query_address = req.query_address;

	atsl_core #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.req       (core_req),
		.res_valid (core_valid),
		.res_ready (core_ready),
		.res       (core_res)
	);

	// output register
	assign core_ready = !out_vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (core_ready) begin
			out_vld_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ready && core_valid) begin
			out_q <= core_res;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.status      = out_q.status;
	assign res.hit_value   = out_q.hit.value;
	assign res.hit_size    = out_q.hit.size;
	assign res.hit_info    = out_q.hit.info;
	assign res.hit_name    = out_q.hit.name;
	assign res.table_count = out_q.table_count;

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - testbench of the address to symbol lookup
// Drives clear, insert and lookup items into the request channel with random
// gaps and stalls the result channel at random. A predictor keeps its own
// sorted symbol table, and every result is compared field by field with the
// oldest predicted one. Directed items cover the edge cases, then random
// phases load the table (twice to full) and resolve addresses around it.
// ----------------------------------------------------------------------------
module tb_top;
	import atsl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = ATSL_TABLE_DEPTH;
	// function code the block does not use
	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1450;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		req_t        req;
		int unsigned gap;
		bit          drain;
	} pend_t;

	logic clk;
	logic arst_n = 1'b0;

	// request channel drive
	logic        drv_valid = 1'b0;
	logic [1:0]  drv_func = FN_CLEAR;
	logic [31:0] drv_value = '0;
	logic [31:0] drv_size = '0;
	logic [7:0]  drv_info = '0;
	logic [31:0] drv_name = '0;
	logic [31:0] drv_addr = '0;
	logic        rx_ready = 1'b0;

	sym_req_if req_ch ();
	sym_res_if res_ch ();

	assign req_ch.valid         = drv_valid;
	assign req_ch.func          = drv_func;
	assign req_ch.entry_value   = drv_value;
	assign req_ch.entry_size    = drv_size;
	assign req_ch.entry_info    = drv_info;
	assign req_ch.entry_name    = drv_name;
	assign req_ch.query_address = drv_addr;
	assign res_ch.ready         = rx_ready;

	address_to_symbol_lookup u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	// predicted symbol table
	key_t        sym_tab [TABLE_DEPTH];
	int unsigned sym_count = 0;

	pend_t       pend_q [$];
	res_t        sym_expect_q [$];
	req_t        cur_req;
	int unsigned n_issued = 0;
	int unsigned n_accepted = 0;
	int unsigned n_queued = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned err_count = 0;
	bit          tx_burst = 1'b0;
	bit          rx_burst = 1'b0;

	// generator state of the current phase
	logic [31:0] phase_vals [$];
	logic [31:0] gen_base;
	bit          gen_narrow;

	// clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// expected result of one item, updates the predicted table
	function automatic res_t predict_symbol(req_t r);
		res_t        o;
		int unsigned pos;
		int unsigned idx;
		o = '0;
		case (r.func)
			FN_CLEAR: begin
				sym_count = 0;
			end
			FN_INSERT: begin
				if (r.key.value == '0 || r.key.name == '0) begin
					o.status = STAT_SKIP;
				end else if (sym_count >= TABLE_DEPTH) begin
					o.status = STAT_FULL;
				end else begin
					// after all equal entries, before the first larger one
					pos = sym_count;
					for (int i = 0; i < sym_count; i++) begin
						if (r.key < sym_tab[i]) begin
							pos = i;
							break;
						end
					end
					for (int i = sym_count; i > pos; i--)
						sym_tab[i] = sym_tab[i - 1];
					sym_tab[pos] = r.key;
					sym_count++;
				end
			end
			FN_LOOKUP: begin
				if (sym_count == 0 || r.query_address < sym_tab[0].value ||
						sym_tab[sym_count - 1].value <= r.query_address) begin
					o.status = STAT_MISS;
				end else begin
					// last entry whose value does not exceed the address
					idx = sym_count - 1;
					while (sym_tab[idx].value > r.query_address)
						idx--;
					o.hit = sym_tab[idx];
				end
			end
			default: ;
		endcase
		o.table_count = 9'(sym_count);
		return o;
	endfunction

	// stimulus helpers
	task automatic add_req(logic [1:0] fn, key_t k, logic [31:0] addr, bit drain);
		pend_t p;
		p.req.func          = fn;
		p.req.key           = k;
		p.req.query_address = addr;
		p.gap               = tx_burst ? 0 : $urandom_range(0, 9);
		p.drain             = drain;
		pend_q.push_back(p);
		n_queued++;
	endtask

	function automatic key_t rand_key();
		key_t k;
		k = {$urandom(), $urandom(), 8'($urandom()), $urandom()};
		return k;
	endfunction

	function automatic logic [31:0] pick_address();
		logic [31:0] v;
		if (phase_vals.size() == 0)
			return $urandom();
		v = phase_vals[$urandom_range(0, phase_vals.size() - 1)];
		case ($urandom_range(0, 6))
			0, 1: return v;
			2: return v - 32'd1;
			3: return v + 32'd1;
			4: return v + 32'($urandom_range(0, 255));
			5: return $urandom();
			default: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
		endcase
	endfunction

	task automatic gen_insert(bit allow_zero);
		key_t k;
		k.value = gen_narrow ? gen_base + 32'($urandom_range(0, 48)) : $urandom();
		if (allow_zero && $urandom_range(0, 19) == 0)
			k.value = '0;
		else if ($urandom_range(0, 29) == 0)
			k.value = '1;
		k.size = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : $urandom();
		k.info = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom());
		k.name = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(1, 4)) : $urandom();
		if (allow_zero && $urandom_range(0, 19) == 0)
			k.name = '0;
		// a full load must not lose entries to the zero rule
		if (!allow_zero && k.value == '0)
			k.value = 32'd1;
		if (!allow_zero && k.name == '0)
			k.name = 32'd1;
		if (k.value != '0)
			phase_vals.push_back(k.value);
		add_req(FN_INSERT, k, $urandom(), 1'b0);
	endtask

	task automatic add_noise();
		key_t k;
		k = rand_key();
		case ($urandom_range(0, 2))
			0: add_req(FN_UNUSED, k, $urandom(), 1'b0);
			1: add_req(FN_LOOKUP, k, $urandom(), 1'b0);
			default: begin
				k.name = '0;
				add_req(FN_INSERT, k, $urandom(), 1'b0);
			end
		endcase
	endtask

	// request driver, changes at the falling edge
	always @(negedge clk) begin : drive_requests
		pend_t nxt;
		if (arst_n) begin
			if (drv_valid && n_accepted != n_issued) begin
				// item still waiting for ready
			end else if (gap_left != 0) begin
				drv_valid <= 1'b0;
				gap_left--;
			end else if (pend_q.size() != 0 &&
					!(pend_q[0].drain && sym_expect_q.size() != 0)) begin
				nxt = pend_q.pop_front();
				drv_func  <= nxt.req.func;
				drv_value <= nxt.req.key.value;
				drv_size  <= nxt.req.key.size;
				drv_info  <= nxt.req.key.info;
				drv_name  <= nxt.req.key.name;
				drv_addr  <= nxt.req.query_address;
				drv_valid <= 1'b1;
				cur_req  = nxt.req;
				gap_left = nxt.gap;
				n_issued++;
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// accepted item: predict its result
	always @(posedge clk) begin : accept_requests
		if (arst_n && req_ch.valid && req_ch.ready) begin
			sym_expect_q.push_back(predict_symbol(cur_req));
			n_accepted++;
		end
	end

	// result ready, changes at the falling edge
	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			rx_ready <= 1'b0;
		end else if (stall_left != 0) begin
			rx_ready <= 1'b0;
			stall_left--;
		end else begin
			rx_ready <= 1'b1;
		end
	end

	task automatic check_field(string label, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, exp_v,
				got_v);
			err_count++;
		end
	endtask

	// result monitor, compares with the oldest prediction
	always @(posedge clk) begin : check_results
		res_t exp_r;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (sym_expect_q.size() == 0) begin
				$display("%0t: result with no item pending, expected none, got status %0d",
					$time, res_ch.status);
				err_count++;
			end else begin
				exp_r = sym_expect_q.pop_front();
				check_field("status", 32'(exp_r.status), 32'(res_ch.status));
				check_field("hit_value", exp_r.hit.value, res_ch.hit_value);
				check_field("hit_size", exp_r.hit.size, res_ch.hit_size);
				check_field("hit_info", 32'(exp_r.hit.info), 32'(res_ch.hit_info));
				check_field("hit_name", exp_r.hit.name, res_ch.hit_name);
				check_field("table_count", 32'(exp_r.table_count), 32'(res_ch.table_count));
			end
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			stall_left = rx_burst ? 0 : $urandom_range(0, 9);
		end
	end

	// stimulus and end of test
	initial begin : run_test
		int unsigned p;
		int unsigned n_ins;
		int unsigned n_look;
		bit          full_load;

		// empty table
		add_req(FN_CLEAR, '0, '0, 1'b1);
		add_req(FN_LOOKUP, '0, 32'h0, 1'b0);
		add_req(FN_LOOKUP, '1, 32'hFFFF_FFFF, 1'b0);
		// zero value and zero name are skipped
		add_req(FN_INSERT, {32'h0, 32'h10, 8'h12, 32'h5}, '0, 1'b0);
		add_req(FN_INSERT, {32'h5, 32'h10, 8'h12, 32'h0}, '0, 1'b0);
		// one entry never hits
		add_req(FN_INSERT, {32'h100, 32'h10, 8'h12, 32'h1}, '0, 1'b0);
		add_req(FN_LOOKUP, '0, 32'h100, 1'b0);
		add_req(FN_LOOKUP, '0, 32'hFF, 1'b0);
		// extremes and a run of equal values with an exact duplicate
		add_req(FN_INSERT, '1, '0, 1'b0);
		add_req(FN_INSERT, {32'h100, 32'h0, 8'h0, 32'h2}, '0, 1'b0);
		add_req(FN_INSERT, {32'h100, 32'hFFFF_FFFF, 8'h0, 32'h3}, '0, 1'b0);
		add_req(FN_INSERT, {32'h100, 32'hFFFF_FFFF, 8'h0, 32'h3}, '0, 1'b0);
		add_req(FN_INSERT, {32'h200, 32'h8, 8'h80, 32'h4}, '0, 1'b0);
		add_req(FN_LOOKUP, '0, 32'h100, 1'b0);
		add_req(FN_LOOKUP, '0, 32'h1FF, 1'b0);
		add_req(FN_LOOKUP, '0, 32'h200, 1'b0);
		add_req(FN_LOOKUP, '0, 32'hFFFF_FFFE, 1'b0);
		add_req(FN_LOOKUP, '0, 32'hFFFF_FFFF, 1'b0);
		add_req(FN_LOOKUP, '0, 32'h0, 1'b0);
		// unused code is ignored
		add_req(FN_UNUSED, '1, 32'hFFFF_FFFF, 1'b0);
		add_req(FN_INSERT, {32'h1, 32'h0, 8'h0, 32'h1}, '0, 1'b0);
		add_req(FN_LOOKUP, '0, 32'h1, 1'b0);
		add_req(FN_CLEAR, '1, '1, 1'b0);
		add_req(FN_LOOKUP, '0, 32'h200, 1'b0);

		// random phases: clear, load, resolve
		p = 0;
		while (n_queued < RANDOM_ITEMS) begin
			full_load  = (p == 2 || p == 7);
			tx_burst   = ($urandom_range(0, 3) == 0);
			gen_narrow = $urandom_range(0, 1);
			gen_base   = $urandom();
			phase_vals.delete();
			add_req(FN_CLEAR, rand_key(), $urandom(), p == 0 || $urandom_range(0, 2) == 0);
			if ($urandom_range(0, 3) == 0)
				add_req(FN_LOOKUP, rand_key(), $urandom(), 1'b0);
			n_ins = full_load ? TABLE_DEPTH + $urandom_range(1, 6) : $urandom_range(1, 24);
			for (int i = 0; i < n_ins; i++) begin
				gen_insert(!full_load);
				if (!full_load && $urandom_range(0, 9) == 0)
					add_noise();
			end
			// zero entry into a full table is still a skip
			if (full_load)
				add_req(FN_INSERT, {32'h0, $urandom(), 8'($urandom()), $urandom()},
					$urandom(), 1'b0);
			n_look = $urandom_range(4, 30);
			for (int i = 0; i < n_look; i++) begin
				add_req(FN_LOOKUP, rand_key(), pick_address(), 1'b0);
				if ($urandom_range(0, 11) == 0)
					add_noise();
			end
			// late inserts on a loaded table
			if (!full_load && $urandom_range(0, 2) == 0) begin
				for (int i = $urandom_range(1, 8); i > 0; i--)
					gen_insert(1'b1);
				for (int i = $urandom_range(2, 10); i > 0; i--)
					add_req(FN_LOOKUP, rand_key(), pick_address(), 1'b0);
			end
			p++;
		end

		// reset
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pend_q.size() != 0 || n_accepted != n_issued)
			@(posedge clk);
		while (sym_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0 && sym_expect_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#4_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
